/* rtl/ggu_pkg.sv */
// shared constants, derivative tables and helper functions for the gelu gradient unit
package ggu_pkg;

  // table geometry: 21 knots over |x| = 0 .. 5.0 in steps of 0.25
  localparam int unsigned TBL_IDX_W = 5;
  localparam int unsigned TBL_W     = 17;
  localparam int unsigned LAST_SEG  = 19;

  // derivative and product widths (q.16 domain)
  localparam int unsigned D_W        = 19;
  localparam int unsigned AD_W       = 18;
  localparam int unsigned M_W        = 18;
  localparam int unsigned PROD_SHIFT = 16;

  localparam logic [TBL_W-1:0] ONE_Q16 = 17'd65536;

  // standard normal cdf, unsigned q1.16
  function automatic logic [TBL_W-1:0] cdf_lut(input logic [TBL_IDX_W-1:0] idx);
    logic [TBL_W-1:0] v;
    unique case (idx)
      5'd0:    v = 17'd32768;
      5'd1:    v = 17'd39237;
      5'd2:    v = 17'd45316;
      5'd3:    v = 17'd50684;
      5'd4:    v = 17'd55138;
      5'd5:    v = 17'd58612;
      5'd6:    v = 17'd61158;
      5'd7:    v = 17'd62911;
      5'd8:    v = 17'd64045;
      5'd9:    v = 17'd64735;
      5'd10:   v = 17'd65129;
      5'd11:   v = 17'd65341;
      5'd12:   v = 17'd65448;
      5'd13:   v = 17'd65498;
      5'd14:   v = 17'd65521;
      5'd15:   v = 17'd65530;
      5'd16:   v = 17'd65534;
      5'd17:   v = 17'd65535;
      5'd18:   v = 17'd65536;
      5'd19:   v = 17'd65536;
      5'd20:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // standard normal pdf, unsigned q0.16
  function automatic logic [TBL_W-1:0] pdf_lut(input logic [TBL_IDX_W-1:0] idx);
    logic [TBL_W-1:0] v;
    unique case (idx)
      5'd0:    v = 17'd26145;
      5'd1:    v = 17'd25341;
      5'd2:    v = 17'd23073;
      5'd3:    v = 17'd19735;
      5'd4:    v = 17'd15858;
      5'd5:    v = 17'd11970;
      5'd6:    v = 17'd8488;
      5'd7:    v = 17'd5654;
      5'd8:    v = 17'd3538;
      5'd9:    v = 17'd2080;
      5'd10:   v = 17'd1149;
      5'd11:   v = 17'd596;
      5'd12:   v = 17'd290;
      5'd13:   v = 17'd133;
      5'd14:   v = 17'd57;
      5'd15:   v = 17'd23;
      5'd16:   v = 17'd9;
      5'd17:   v = 17'd3;
      5'd18:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/ggu_in_if.sv */
// input channel: activation and upstream gradient with valid/ready
interface ggu_in_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] activation;
  logic signed [DATA_WIDTH-1:0] upstream_grad;

  modport source (output valid, output activation, output upstream_grad, input ready);
  modport sink   (input valid, input activation, input upstream_grad, output ready);
endinterface

/* rtl/ggu_out_if.sv */
// output channel: input gradient and saturation flag with valid/ready
interface ggu_out_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] input_grad;
  logic                         saturated;

  modport source (output valid, output input_grad, output saturated, input ready);
  modport sink   (input valid, input input_grad, input saturated, output ready);
endinterface

/* rtl/gelu_gradient_unit_core.sv */
// top level of the gelu gradient unit: derivative pipeline followed by scale pipeline
//
// Streams one element per clock while out_o takes results: each transaction on in_i carries
// an activation x and an upstream gradient dy in signed fixed point (FRAC_BITS fraction
// bits, DATA_WIDTH bits), and the matching transaction on out_o carries dx = dy * gelu'(x),
// rounded to nearest with ties away from zero and clipped to the signed range (saturated
// flags a clip). The result passes through six register stages, and throughput is one
// transaction per cycle while out_o takes results. Stages: table read, interpolation
// multiply, x*phi multiply, derivative combine, gradient multiply, saturation. Each stage
// holds its own valid bit and advances whenever the stage after it has room, so bubbles
// collapse under backpressure and in_i.ready can stay high while a result waits on out_o.
// The derivative uses 21-knot cdf/pdf tables over |x| in [0, 5) with truncated linear
// interpolation; for |x| >= 5 it is 1 for positive and 0 for negative x. There is no state
// beyond the pipeline and nothing to configure.
module gelu_gradient_unit_core #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ggu_in_if.sink    in_i,
  ggu_out_if.source out_o
);

  // handshake between the two pipelines
  logic                     mid_valid;
  logic                     mid_ready;
  logic [ggu_pkg::AD_W-1:0] mid_ad;
  logic [DATA_WIDTH-1:0]    mid_ady;
  logic                     mid_neg;

  // stages 1..4: |G'(x)| in q.16, |dy|, result sign
  ggu_deriv #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_deriv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .act_i       (in_i.activation),
    .dy_i        (in_i.upstream_grad),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .ad_o        (mid_ad),
    .ady_o       (mid_ady),
    .neg_o       (mid_neg)
  );

  // stages 5..6: rounded product and saturation, output register
  ggu_scale #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .ad_i        (mid_ad),
    .ady_i       (mid_ady),
    .neg_i       (mid_neg),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .grad_o      (out_o.input_grad),
    .sat_o       (out_o.saturated)
  );

  // transactions in flight, for checking only
  localparam int unsigned DEPTH  = 6;
  localparam int unsigned OCC_W  = 3;
  localparam logic signed [DATA_WIDTH-1:0] GRAD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] GRAD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic             in_fire, out_fire;
  logic [OCC_W-1:0] occ_d, occ_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin
    occ_d = occ_q;
    if (in_fire && !out_fire) begin
      occ_d = OCC_W'(occ_q + OCC_W'(1));
    end else if (out_fire && !in_fire) begin
      occ_d = OCC_W'(occ_q - OCC_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // pipeline never holds more transactions than it has stages
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= OCC_W'(DEPTH))
    else $error("more transactions in flight than pipeline stages");

  // a result is never presented without a matching accepted input
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_o.valid |-> occ_q != '0)
    else $error("result presented with nothing in flight");

  // a full pipeline stalled at the output must refuse new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (occ_q == OCC_W'(DEPTH) && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted into a full stalled pipeline");

  // a clipped result sits exactly on a range bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && out_o.saturated) |->
                   (out_o.input_grad == GRAD_MAX || out_o.input_grad == GRAD_MIN))
    else $error("saturated result is not a range bound");

  // a zero result is never flagged as clipped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && out_o.input_grad == '0) |-> !out_o.saturated)
    else $error("zero result flagged as saturated");

endmodule

/* rtl/ggu_deriv.sv */
// four-stage pipeline computing |G'(x)| in q.16, |dy| and the result sign
module ggu_deriv #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]  act_i,
  input  logic signed [DATA_WIDTH-1:0]  dy_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ggu_pkg::AD_W-1:0]      ad_o,
  output logic [DATA_WIDTH-1:0]         ady_o,
  output logic                          neg_o
);

  localparam int unsigned SEG_BITS = FRAC_BITS - 2;
  localparam int unsigned AEXT_W   = (DATA_WIDTH > FRAC_BITS + 3) ? DATA_WIDTH : FRAC_BITS + 3;
  localparam int unsigned TW       = ggu_pkg::TBL_W;
  localparam int unsigned IW       = ggu_pkg::TBL_IDX_W;
  localparam int unsigned DW       = ggu_pkg::D_W;
  localparam int unsigned MPROD_W  = AEXT_W + TW;
  localparam logic [AEXT_W-1:0] LIMIT = AEXT_W'(5) << FRAC_BITS;

  // stage enables, back to front
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: magnitude, range check, table reads
  logic [DATA_WIDTH-1:0] a_abs;
  logic [AEXT_W-1:0]     a_ext;
  logic [IW-1:0]         seg_raw, seg, seg_nx;

  assign a_abs   = act_i[DATA_WIDTH-1] ? DATA_WIDTH'(-act_i) : DATA_WIDTH'(act_i);
  assign a_ext   = AEXT_W'(a_abs);
  assign seg_raw = a_ext[SEG_BITS +: IW];
  assign seg     = (seg_raw > IW'(ggu_pkg::LAST_SEG)) ? IW'(ggu_pkg::LAST_SEG) : seg_raw;
  assign seg_nx  = IW'(seg + IW'(1));

  logic                         neg1_q, large1_q;
  logic [AEXT_W-1:0]            a1_q;
  logic [SEG_BITS-1:0]          frac1_q;
  logic [TW-1:0]                plo1_q, phi1_q, glo1_q, ghi1_q;
  logic signed [DATA_WIDTH-1:0] dy1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      neg1_q   <= act_i[DATA_WIDTH-1];
      large1_q <= (a_ext >= LIMIT);
      a1_q     <= a_ext;
      frac1_q  <= a_ext[SEG_BITS-1:0];
      plo1_q   <= ggu_pkg::cdf_lut(seg);
      phi1_q   <= ggu_pkg::cdf_lut(seg_nx);
      glo1_q   <= ggu_pkg::pdf_lut(seg);
      ghi1_q   <= ggu_pkg::pdf_lut(seg_nx);
      dy1_q    <= dy_i;
    end
  end

  // stage 2: linear interpolation, truncated
  logic                    p_rise, g_rise;
  logic [TW-1:0]           p_diff, g_diff, p_step, g_step;
  logic [TW+SEG_BITS-1:0]  p_prod, g_prod;

  assign p_rise = phi1_q >= plo1_q;
  assign g_rise = ghi1_q >= glo1_q;
  assign p_diff = p_rise ? (phi1_q - plo1_q) : (plo1_q - phi1_q);
  assign g_diff = g_rise ? (ghi1_q - glo1_q) : (glo1_q - ghi1_q);
  assign p_prod = (TW + SEG_BITS)'(p_diff) * (TW + SEG_BITS)'(frac1_q);
  assign g_prod = (TW + SEG_BITS)'(g_diff) * (TW + SEG_BITS)'(frac1_q);
  assign p_step = p_prod[SEG_BITS +: TW];
  assign g_step = g_prod[SEG_BITS +: TW];

  logic                         neg2_q, large2_q;
  logic [AEXT_W-1:0]            a2_q;
  logic [TW-1:0]                p2_q, g2_q;
  logic signed [DATA_WIDTH-1:0] dy2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      neg2_q   <= neg1_q;
      large2_q <= large1_q;
      a2_q     <= a1_q;
      p2_q     <= p_rise ? (plo1_q + p_step) : (plo1_q - p_step);
      g2_q     <= g_rise ? (glo1_q + g_step) : (glo1_q - g_step);
      dy2_q    <= dy1_q;
    end
  end

  // stage 3: x * phi(x)
  logic [MPROD_W-1:0] m_prod;

  assign m_prod = MPROD_W'(a2_q) * MPROD_W'(g2_q);

  logic                         neg3_q, large3_q;
  logic [TW-1:0]                p3_q;
  logic [ggu_pkg::M_W-1:0]      m3_q;
  logic signed [DATA_WIDTH-1:0] dy3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      neg3_q   <= neg2_q;
      large3_q <= large2_q;
      p3_q     <= p2_q;
      m3_q     <= m_prod[FRAC_BITS +: ggu_pkg::M_W];
      dy3_q    <= dy2_q;
    end
  end

  // stage 4: combine, take magnitudes and sign
  logic signed [DW-1:0] p_s, m_s, one_s, d_val;
  logic                 d_neg, dy_neg;

  assign p_s   = DW'(p3_q);
  assign m_s   = DW'(m3_q);
  assign one_s = DW'(ggu_pkg::ONE_Q16);

  always_comb begin
    priority if (large3_q) begin
      d_val = neg3_q ? '0 : one_s;
    end else if (neg3_q) begin
      d_val = (one_s - p_s) - m_s;
    end else begin
      d_val = p_s + m_s;
    end
  end

  assign d_neg  = d_val[DW-1];
  assign dy_neg = dy3_q[DATA_WIDTH-1];

  always_ff @(posedge clk_i) begin
    if (en4) begin
      ad_o  <= d_neg ? ggu_pkg::AD_W'(-d_val) : ggu_pkg::AD_W'(d_val);
      ady_o <= dy_neg ? DATA_WIDTH'(-dy3_q) : DATA_WIDTH'(dy3_q);
      neg_o <= d_neg != dy_neg;
    end
  end

endmodule

/* rtl/ggu_scale.sv */
// two-stage pipeline: rounded product |d|*|dy| and signed saturation
module ggu_scale #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ggu_pkg::AD_W-1:0]      ad_i,
  input  logic [DATA_WIDTH-1:0]         ady_i,
  input  logic                          neg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [DATA_WIDTH-1:0]  grad_o,
  output logic                          sat_o
);

  localparam int unsigned PW    = ggu_pkg::AD_W + DATA_WIDTH + 1;
  localparam int unsigned MAG_W = PW - ggu_pkg::PROD_SHIFT;
  localparam logic [MAG_W-1:0] POS_MAX = MAG_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(64'd1 << (DATA_WIDTH - 1));
  localparam logic [PW-1:0]    HALF    = PW'(64'd1 << (ggu_pkg::PROD_SHIFT - 1));

  logic v5_q, v6_q;
  logic en5, en6;

  assign en6         = !v6_q || out_ready_i;
  assign en5         = !v5_q || en6;
  assign in_ready_o  = en5;
  assign out_valid_o = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en5) v5_q <= in_valid_i;
      if (en6) v6_q <= v5_q;
    end
  end

  // stage 5: multiply and round half away from zero on the magnitude
  logic [PW-1:0] prod;

  assign prod = (PW'(ad_i) * PW'(ady_i)) + HALF;

  logic [MAG_W-1:0] mag5_q;
  logic             neg5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      mag5_q <= prod[ggu_pkg::PROD_SHIFT +: MAG_W];
      neg5_q <= neg_i;
    end
  end

  // stage 6: clip to the signed range
  logic             clip;
  logic [MAG_W-1:0] mag_c;

  always_comb begin
    if (neg5_q) begin
      clip  = mag5_q > NEG_MAX;
      mag_c = clip ? NEG_MAX : mag5_q;
    end else begin
      clip  = mag5_q > POS_MAX;
      mag_c = clip ? POS_MAX : mag5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      grad_o <= neg5_q ? DATA_WIDTH'(-mag_c) : DATA_WIDTH'(mag_c);
      sat_o  <= clip;
    end
  end

endmodule
